// ===== hdl/next_fit_id_allocator_top_macros.svh =====
// Assertion macros for the next-fit identifier allocator.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef NEXT_FIT_ID_ALLOCATOR_TOP_MACROS_SVH
`define NEXT_FIT_ID_ALLOCATOR_TOP_MACROS_SVH

`ifndef SYNTH
`define NFA_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nfa implication check failed");
`define NFA_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("nfa invariant check failed");
`else
`define NFA_ASSERT_IMPL(lbl, clk, rst, ante, cons)
`define NFA_ASSERT_ALWAYS(lbl, clk, rst, cond)
`endif

`endif

// ===== hdl/nfa_pkg.sv =====
// Shared types and constants of the next-fit identifier allocator.
// No dependencies; imported by every module of the block.
package nfa_pkg;

   localparam int ID_W     = 8;
   localparam int WORD_W   = 32;
   localparam int OFF_W    = 5;
   localparam int MAX_POOL = 1 << ID_W;

   localparam logic REQ_ALLOC   = 1'b0;
   localparam logic REQ_RELEASE = 1'b1;

   localparam logic [1:0] ST_ALLOCATED = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_RELEASED  = 2'd2;
   localparam logic [1:0] ST_NOT_USED  = 2'd3;

   typedef struct packed {
      logic            req_type;
      logic [ID_W-1:0] release_id;
   } nfa_req_type;

   typedef struct packed {
      logic [ID_W-1:0] granted_id;
      logic [1:0]      status;
   } nfa_rsp_type;

   typedef struct packed {
      logic             found;
      logic [OFF_W-1:0] pos;
   } nfa_scan_type;

endpackage

// ===== hdl/next_fit_id_allocator_top.sv =====
// Next-fit identifier allocator: hands out nonzero ids from a pool of
// min(ID_COUNT, 256) and takes them back, one transaction at a time. The used
// map sits in a bitmap memory of 32-bit rows with a single read port; an
// allocate reads one row per cycle, starting at the row of the next pointer and
// wrapping, and stops at the first row with a free id or, when there is none,
// after it has visited every row and the start row again. A release of id zero
// or of an id outside the pool does not read the map. A finished result is held
// in the output register while the next transaction is taken. The bitmap needs
// no clearing pass after reset.
`include "next_fit_id_allocator_top_macros.svh"

module next_fit_id_allocator_top import nfa_pkg::*; #(
   parameter int ID_COUNT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  nfa_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output nfa_rsp_type rsp_data
);

   localparam int POOL_SIZE = (ID_COUNT < MAX_POOL) ? ID_COUNT : MAX_POOL;
   localparam int MAP_WORDS = (POOL_SIZE + WORD_W - 1) / WORD_W;
   localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int STEP_W    = $clog2(MAP_WORDS + 1);

   localparam logic [ID_W:0]      POOL_W    = (ID_W+1)'(POOL_SIZE);
   localparam logic [WORD_AW-1:0] LAST_ADDR = WORD_AW'(MAP_WORDS - 1);
   localparam logic [STEP_W-1:0]  LAST_STEP = STEP_W'(MAP_WORDS);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_REL  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [WORD_AW-1:0] addr_ff, addr_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic [ID_W-1:0]    next_probe_ff, next_probe_in;
   nfa_rsp_type        res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   nfa_rsp_type        rsp_data_ff, rsp_data_in;

   logic               rd_en;
   logic [WORD_AW-1:0] rd_addr;
   logic [WORD_W-1:0]  rd_data;
   logic               wr_en;
   logic [WORD_AW-1:0] wr_addr;
   logic [WORD_W-1:0]  wr_data;

   logic               accept;
   logic               rel_ok;
   logic [WORD_AW-1:0] probe_word;
   logic [WORD_AW-1:0] rel_word;
   logic [WORD_AW-1:0] addr_next;
   logic [ID_W-1:0]    granted;
   logic [ID_W:0]      grant_inc;
   nfa_scan_type       scan_res;

   nfa_map_mem #(
      .WORDS (MAP_WORDS),
      .AW    (WORD_AW)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   nfa_word_scan #(
      .POOL_SIZE (POOL_SIZE),
      .AW        (WORD_AW)
   ) u_scan (
      .word     (rd_data),
      .addr     (addr_ff),
      .first    (step_ff == '0),
      .last     (step_ff == LAST_STEP),
      .off      (off_ff),
      .scan_res (scan_res)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign accept     = req_valid && !req_stall;
   assign probe_word = WORD_AW'(next_probe_ff >> OFF_W);
   assign rel_word   = WORD_AW'(req_data.release_id >> OFF_W);
   assign rel_ok     = (req_data.release_id != '0) && ({1'b0, req_data.release_id} < POOL_W);
   assign addr_next  = (addr_ff == LAST_ADDR) ? '0 : addr_ff + 1'b1;
   assign granted    = (ID_W'(addr_ff) << OFF_W) | ID_W'(scan_res.pos);
   assign grant_inc  = {1'b0, granted} + (ID_W+1)'(1);

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      addr_in       = addr_ff;
      off_in        = off_ff;
      next_probe_in = next_probe_ff;
      res_in        = res_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff;
      rd_en         = 1'b0;
      rd_addr       = addr_ff;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = rd_data;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // the map is only written in the cycle that ends a transaction and read
      // again no earlier than the next acceptance, so no forwarding is needed
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_data.req_type == REQ_ALLOC) begin
                  rd_en    = 1'b1;
                  rd_addr  = probe_word;
                  addr_in  = probe_word;
                  step_in  = '0;
                  off_in   = next_probe_ff[OFF_W-1:0];
                  state_in = S_SCAN;
               end else if (rel_ok) begin
                  rd_en    = 1'b1;
                  rd_addr  = rel_word;
                  addr_in  = rel_word;
                  off_in   = req_data.release_id[OFF_W-1:0];
                  state_in = S_REL;
               end else begin
                  res_in   = '{granted_id: '0, status: ST_NOT_USED};
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            if (scan_res.found) begin
               wr_en         = 1'b1;
               wr_data       = rd_data | (WORD_W'(1) << scan_res.pos);
               res_in        = '{granted_id: granted, status: ST_ALLOCATED};
               next_probe_in = (grant_inc == POOL_W) ? '0 : grant_inc[ID_W-1:0];
               state_in      = S_DONE;
            end else if (step_ff == LAST_STEP) begin
               res_in   = '{granted_id: '0, status: ST_FULL};
               state_in = S_DONE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = addr_next;
               addr_in = addr_next;
               step_in = step_ff + 1'b1;
            end
         end
         S_REL: begin
            if (rd_data[off_ff]) begin
               wr_en   = 1'b1;
               wr_data = rd_data & ~(WORD_W'(1) << off_ff);
               res_in  = '{granted_id: '0, status: ST_RELEASED};
            end else begin
               res_in  = '{granted_id: '0, status: ST_NOT_USED};
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         next_probe_ff <= ID_W'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         next_probe_ff <= next_probe_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff     <= step_in;
      addr_ff     <= addr_in;
      off_ff      <= off_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `NFA_ASSERT_IMPL(a_grant_in_pool, clock, reset,
      rsp_valid_ff && (rsp_data_ff.status == ST_ALLOCATED),
      (rsp_data_ff.granted_id != '0) && (rsp_data_ff.granted_id < POOL_W))
   `NFA_ASSERT_IMPL(a_no_id_without_grant, clock, reset,
      rsp_valid_ff && (rsp_data_ff.status != ST_ALLOCATED),
      rsp_data_ff.granted_id == '0)
   `NFA_ASSERT_ALWAYS(a_probe_in_pool, clock, reset, next_probe_ff < POOL_W)
   `NFA_ASSERT_IMPL(a_grant_was_free, clock, reset,
      (state_ff == S_SCAN) && scan_res.found, !rd_data[scan_res.pos])
   `NFA_ASSERT_IMPL(a_no_rw_overlap, clock, reset, rd_en && wr_en, rd_addr != wr_addr)

endmodule

// ===== hdl/nfa_map_mem.sv =====
// Used-identifier bitmap: one 32-bit word per row, registered read.
// Depends on nfa_pkg. Per-row valid bits make unwritten rows read as all free.
module nfa_map_mem import nfa_pkg::*; #(
   parameter int WORDS = 8,
   parameter int AW    = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [WORD_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [WORD_W-1:0] wr_data
);

   logic [WORD_W-1:0] map_ff [WORDS];
   logic [WORDS-1:0]  vld_ff;
   logic [WORD_W-1:0] data_ff;
   logic              hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         data_ff <= map_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            hit_ff <= vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = hit_ff ? data_ff : '0;

endmodule

// ===== hdl/nfa_word_scan.sv =====
// Evaluates one bitmap word of a next-fit search: masks and lowest free bit.
// Depends on nfa_pkg.
module nfa_word_scan import nfa_pkg::*; #(
   parameter int POOL_SIZE = 256,
   parameter int AW        = 3
) (
   input  logic [WORD_W-1:0] word,
   input  logic [AW-1:0]     addr,
   input  logic              first,
   input  logic              last,
   input  logic [OFF_W-1:0]  off,
   output nfa_scan_type      scan_res
);

   localparam logic [ID_W:0] POOL_W = (ID_W+1)'(POOL_SIZE);

   logic [WORD_W-1:0] free;
   logic [ID_W:0]     id9;

   // first word of a search looks at and above the start bit, the wrap
   // visit of the same word only below it; id 0 and ids past the pool never count
   always_comb begin
      free     = '0;
      scan_res = '0;
      id9      = '0;
      for (int b = 0; b < WORD_W; b++) begin
         id9     = ((ID_W+1)'(addr) << OFF_W) | (ID_W+1)'(b);
         free[b] = !word[b] && (id9 != '0) && (id9 < POOL_W)
                   && (!first || (OFF_W'(b) >= off))
                   && (!last || (OFF_W'(b) < off));
      end
      for (int b = WORD_W - 1; b >= 0; b--) begin
         if (free[b]) begin
            scan_res.found = 1'b1;
            scan_res.pos   = OFF_W'(b);
         end
      end
   end

endmodule

// ===== tb/next_fit_id_allocator_top_test.sv =====
// Self-checking testbench of the next-fit identifier allocator top level.
// Depends on nfa_pkg and next_fit_id_allocator_top; keeps its own copy of the used map.
module next_fit_id_allocator_top_test;
   import nfa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ID_COUNT    = 256;
   localparam int POOL        = (ID_COUNT < MAX_POOL) ? ID_COUNT : MAX_POOL;
   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 16;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   nfa_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   nfa_rsp_type rsp_data;

   // predictor state
   logic [MAX_POOL-1:0] id_used;
   logic [ID_W-1:0]     probe_start;
   nfa_rsp_type         pending_results[$];
   nfa_rsp_type         oldest_result;

   int tx_idle_pct;
   int rx_idle_pct;
   int failures;
   int quiet_cycles;

   next_fit_id_allocator_top #(.ID_COUNT(ID_COUNT)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic nfa_rsp_type allocate_or_release(input nfa_req_type r);
      nfa_rsp_type res;
      int unsigned probe;
      int          n;
      logic        found;
      res   = '0;
      found = 1'b0;
      if (r.req_type == REQ_ALLOC) begin
         res.status = ST_FULL;
         probe = probe_start % POOL;
         for (n = 0; n < POOL; n++) begin
            // id zero is never handed out, so a search passing it skips on
            if (!found && probe != 0 && !id_used[probe]) begin
               id_used[probe] = 1'b1;
               res.granted_id = probe[ID_W-1:0];
               res.status     = ST_ALLOCATED;
               probe_start    = ID_W'((probe + 1) % POOL);
               found          = 1'b1;
            end
            probe = (probe + 1) % POOL;
         end
      end else begin
         if (r.release_id != 0 && int'(r.release_id) < POOL && id_used[r.release_id]) begin
            id_used[r.release_id] = 1'b0;
            res.status = ST_RELEASED;
         end else begin
            res.status = ST_NOT_USED;
         end
      end
      return res;
   endfunction

   function automatic logic [ID_W-1:0] pick_used_id();
      int unsigned start;
      int unsigned id;
      int          n;
      logic [ID_W-1:0] pick;
      start = $urandom_range(0, MAX_POOL - 1);
      pick  = ID_W'($urandom_range(0, MAX_POOL - 1));
      for (n = MAX_POOL - 1; n >= 0; n--) begin
         id = (start + n) % MAX_POOL;
         if (id_used[id]) pick = ID_W'(id);
      end
      return pick;
   endfunction

   // keeps valid high between back-to-back transactions; lowers it only for a gap
   task automatic send_request(input logic kind, input logic [ID_W-1:0] id);
      nfa_req_type r;
      int          gap;
      r.req_type   = kind;
      r.release_id = id;
      gap = 0;
      while (gap < 30 && $urandom_range(0, 99) < tx_idle_pct) gap++;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_results.push_back(allocate_or_release(r));
   endtask

   task automatic hold_until_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed_basics();
      send_request(REQ_ALLOC, 8'h00);
      send_request(REQ_ALLOC, 8'hFF);
      send_request(REQ_RELEASE, 8'h01);
      send_request(REQ_RELEASE, 8'h01);   // already free
      send_request(REQ_RELEASE, 8'h00);   // zero is never used
      send_request(REQ_RELEASE, 8'hFF);   // never allocated
      send_request(REQ_RELEASE, 8'hAA);
      send_request(REQ_ALLOC, 8'h55);
      send_request(REQ_ALLOC, 8'hAA);
      send_request(REQ_RELEASE, 8'h02);
      send_request(REQ_RELEASE, 8'h03);
      send_request(REQ_ALLOC, 8'h00);
   endtask

   task automatic test_pool_exhaustion();
      while ($countones(id_used) < POOL - 1)
         send_request(REQ_ALLOC, ID_W'($urandom_range(0, MAX_POOL - 1)));
      send_request(REQ_ALLOC, 8'h00);
      send_request(REQ_ALLOC, 8'hFF);
      // make 255 the only free id so the pointer wraps to zero
      send_request(REQ_RELEASE, 8'hFF);
      send_request(REQ_ALLOC, 8'h00);
      send_request(REQ_RELEASE, 8'h07);
      send_request(REQ_ALLOC, 8'h00);     // search starts at zero and skips it
      send_request(REQ_RELEASE, 8'hFF);
      send_request(REQ_RELEASE, 8'hFF);
      hold_until_drained();
      send_request(REQ_ALLOC, 8'h00);
   endtask

   task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
      int   i;
      int   alloc_bias;
      logic kind;
      logic [ID_W-1:0] id;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      alloc_bias  = 50;
      for (i = 0; i < count; i++) begin
         // bias swings in chunks so the pool both fills up and drains
         if (i % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: alloc_bias = 25;
               1: alloc_bias = 55;
               default: alloc_bias = 90;
            endcase
         end
         kind = ($urandom_range(0, 99) < alloc_bias) ? REQ_ALLOC : REQ_RELEASE;
         id   = ID_W'($urandom_range(0, MAX_POOL - 1));
         if (kind == REQ_RELEASE && $urandom_range(0, 99) < 75) id = pick_used_id();
         send_request(kind, id);
      end
   endtask

   always @(negedge clock) rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: granted_id %0d status %0d",
                   rsp_data.granted_id, rsp_data.status);
            failures++;
         end else begin
            oldest_result = pending_results.pop_front();
            if (rsp_data.granted_id !== oldest_result.granted_id) begin
               $error("granted_id: expected %0d, actual %0d",
                      oldest_result.granted_id, rsp_data.granted_id);
               failures++;
            end
            if (rsp_data.status !== oldest_result.status) begin
               $error("status: expected %0d, actual %0d",
                      oldest_result.status, rsp_data.status);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("[next_fit_id_allocator_top] ERROR");
         $finish;
      end
   end

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      tx_idle_pct  = 27;
      rx_idle_pct  = 52;
      id_used      = '0;
      probe_start  = ID_W'(1);
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_basics();
      test_pool_exhaustion();
      test_random_traffic(27, 52, 220);
      hold_until_drained();
      test_random_traffic(52, 27, 220);
      test_random_traffic(0, 0, 220);

      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (failures == 0 && pending_results.size() == 0)
         $display("[next_fit_id_allocator_top] OK");
      else
         $display("[next_fit_id_allocator_top] ERROR");
      $finish;
   end

endmodule

// ===== next_fit_id_allocator_top.f =====
+incdir+hdl
hdl/nfa_pkg.sv
hdl/nfa_map_mem.sv
hdl/nfa_word_scan.sv
hdl/next_fit_id_allocator_top.sv
tb/next_fit_id_allocator_top_test.sv
